@@ hdl/crd_pkg.sv @@
// crd_pkg: shared types, constants and arithmetic steps of the camera ray block
// used by crd_basis, crd_ray_pipe and camera_ray_direction; no dependencies
package crd_pkg;

    localparam int UNIT_FRAC     = 30;
    localparam int DIR_FRAC_BITS = 14;
    localparam int FRAG_FRAC     = 14;
    localparam int FOCAL_FRAC    = 12;
    localparam int FOCAL_SHIFT   = FRAG_FRAC - FOCAL_FRAC;
    localparam int SQRT_STEPS    = 31;
    localparam int DIV_STEPS     = 31;
    localparam int RND_SHIFT     = 2 * UNIT_FRAC - DIR_FRAC_BITS;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_EYE_X    = 3'd0,
        REG_EYE_Y    = 3'd1,
        REG_EYE_Z    = 3'd2,
        REG_TARGET_X = 3'd3,
        REG_TARGET_Y = 3'd4,
        REG_TARGET_Z = 3'd5,
        REG_FOCAL    = 3'd6
    } cfg_reg_t;

    // basis sequencer states
    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_PREP,
        B_SHIFT,
        B_SQUARE,
        B_SQRT,
        B_DIVLOAD,
        B_DIV,
        B_STORE,
        B_CROSS,
        B_CVOUT
    } bstate_t;

    typedef struct packed {
        logic signed [15:0] frag_x;
        logic signed [15:0] frag_y;
    } frag_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               degenerate;
    } ray_t;

    // camera basis, Q1.30 components, index 0 is x
    typedef struct packed {
        logic [2:0][31:0] cu;
        logic [2:0][31:0] cv;
        logic [2:0][31:0] cw;
        logic             degenerate;
    } basis_t;

    // digit-by-digit square root state
    typedef struct packed {
        logic [61:0] x;
        logic [62:0] r;
    } sq_t;

    // restoring division state
    typedef struct packed {
        logic [30:0] rem;
        logic [30:0] q;
    } dv_t;

    // one root step with trial bit 4^i
    function automatic sq_t sqrt_step(input sq_t s, input logic [4:0] i);
        logic [62:0] b;
        logic [62:0] t;
        sq_t         o;
        b = 63'(1) << {i, 1'b0};
        t = s.r + b;
        if ({1'b0, s.x} >= t) begin
            o.x = 62'({1'b0, s.x} - t);
            o.r = (s.r >> 1) + b;
        end else begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit; remainder stays below n
    function automatic dv_t div_step(input dv_t s, input logic din, input logic [30:0] n);
        logic [31:0] rem2;
        dv_t         o;
        rem2 = {s.rem, din};
        if (rem2 >= {1'b0, n}) begin
            o.rem = 31'(rem2 - {1'b0, n});
            o.q   = {s.q[29:0], 1'b1};
        end else begin
            o.rem = rem2[30:0];
            o.q   = {s.q[29:0], 1'b0};
        end
        return o;
    endfunction

    // right shift rounding half away from zero, s >= 1
    function automatic logic signed [63:0] rnd_half(input logic signed [63:0] x, input int s);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + (64'(1) << (s - 1))) >> s;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    // full signed 32 by 32 product
    function automatic logic signed [63:0] smul32(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = $signed({{32{a[31]}}, a});
        eb = $signed({{32{b[31]}}, b});
        return ea * eb;
    endfunction

endpackage

@@ hdl/crd_basis.sv @@
// crd_basis: sequential camera basis builder (cw, cu, cv) from eye and target
// depends on crd_pkg for the root and divide steps and the basis type
module crd_basis
    import crd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             kick,
    input  logic [2:0][31:0] eye,
    input  logic [2:0][31:0] target,
    output basis_t           basis,
    output logic             busy
);

    bstate_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg;
    logic       phase_reg;
    logic       degen_reg;

    logic [2:0][32:0] d_reg;
    logic [2:0][32:0] vin_reg;
    logic [2:0]       neg_reg;
    logic [2:0][32:0] mag_reg;
    logic [32:0]      mx_reg;
    logic [2:0][29:0] m_reg;
    logic [61:0]      sum_reg;
    sq_t              s_reg;
    logic [30:0]      n_reg;
    dv_t              dv_reg;
    logic [30:0]      dlo_reg;
    logic [2:0][31:0] cw_reg;
    logic [2:0][31:0] cu_reg;
    logic [2:0][31:0] cv_reg;
    logic [3:0][63:0] p_reg;

    logic [2:0][32:0] d_now;
    logic             d_zero;
    logic [2:0][32:0] mag_now;
    logic [32:0]      mx_now;
    sq_t              s_in;
    logic [5:0]       msb;
    logic [60:0]      dividend;
    logic [31:0]      qval;

    // position of the leading one
    function automatic logic [5:0] msb33(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // offset from eye to target
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            d_now[i] = {target[i][31], target[i]} - {eye[i][31], eye[i]};
        end
        d_zero   = (d_now[0] == '0) && (d_now[2] == '0);
        s_in     = (cnt_reg == '0) ? sq_t'{x: sum_reg, r: '0} : s_reg;
        msb      = msb33(mx_reg);
        dividend = {1'b0, m_reg[comp_reg], 30'b0} + 61'(s_reg.r[30:1]);
        qval     = neg_reg[comp_reg] ? -{1'b0, dv_reg.q} : {1'b0, dv_reg.q};
    end

    // magnitudes of the vector being normalized and the largest of them
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            mag_now[i] = vin_reg[i][32] ? 33'(-vin_reg[i]) : vin_reg[i];
        end
        mx_now = '0;
        for (int i = 0; i < 3; i++) begin
            if (mag_now[i] > mx_now) begin
                mx_now = mag_now[i];
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            B_IDLE: state_next = B_IDLE;
            B_START: state_next = d_zero ? B_IDLE : B_PREP;
            B_PREP: state_next = B_SHIFT;
            B_SHIFT: state_next = B_SQUARE;
            B_SQUARE:
            begin
                if (cnt_reg == 5'd2) begin
                    state_next = B_SQRT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            B_SQRT:
            begin
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    state_next = B_DIVLOAD;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            B_DIVLOAD: state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = B_STORE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            B_STORE:
            begin
                if (comp_reg != 2'd2) begin
                    state_next = B_DIVLOAD;
                end else if (!phase_reg) begin
                    state_next = B_PREP;
                end else begin
                    state_next = B_CROSS;
                end
            end
            B_CROSS:
            begin
                if (cnt_reg == 5'd3) begin
                    state_next = B_CVOUT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            B_CVOUT: state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
        if (kick) begin
            state_next = B_START;
            cnt_next   = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            phase_reg <= 1'b0;
            degen_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == B_START) begin
                phase_reg <= 1'b0;
                degen_reg <= d_zero;
            end
            if (state_reg == B_SQRT) begin
                comp_reg <= '0;
            end
            if (state_reg == B_STORE) begin
                comp_reg <= comp_reg + 2'd1;
                if (comp_reg == 2'd2) begin
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_START:
            begin
                d_reg   <= d_now;
                vin_reg <= d_now;
            end
            B_PREP:
            begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= vin_reg[i][32];
                end
                mag_reg <= mag_now;
                mx_reg  <= mx_now;
            end
            B_SHIFT:
            begin
                for (int i = 0; i < 3; i++) begin
                    if (msb > 6'd29) begin
                        m_reg[i] <= 30'({30'b0, mag_reg[i]} >> (msb - 6'd29));
                    end else begin
                        m_reg[i] <= 30'({30'b0, mag_reg[i]} << (6'd29 - msb));
                    end
                end
                sum_reg <= '0;
            end
            B_SQUARE:
            begin
                sum_reg <= sum_reg + 62'(60'(m_reg[cnt_reg[1:0]]) * 60'(m_reg[cnt_reg[1:0]]));
            end
            B_SQRT:
            begin
                s_reg <= sqrt_step(s_in, 5'(SQRT_STEPS - 1) - cnt_reg);
            end
            B_DIVLOAD:
            begin
                n_reg     <= s_reg.r[30:0];
                dv_reg    <= '{rem: {1'b0, dividend[60:31]}, q: '0};
                dlo_reg   <= dividend[30:0];
            end
            B_DIV:
            begin
                dv_reg  <= div_step(dv_reg, dlo_reg[30], n_reg);
                dlo_reg <= {dlo_reg[29:0], 1'b0};
            end
            B_STORE:
            begin
                if (!phase_reg) begin
                    cw_reg[comp_reg] <= qval;
                end else begin
                    cu_reg[comp_reg] <= qval;
                end
                // right axis comes from (-dz, 0, dx)
                if (comp_reg == 2'd2 && !phase_reg) begin
                    vin_reg[0] <= -d_reg[2];
                    vin_reg[1] <= '0;
                    vin_reg[2] <= d_reg[0];
                end
            end
            B_CROSS:
            begin
                unique case (cnt_reg[1:0])
                    2'd0: p_reg[0] <= smul32(cu_reg[2], cw_reg[1]);
                    2'd1: p_reg[1] <= smul32(cu_reg[2], cw_reg[0]);
                    2'd2: p_reg[2] <= smul32(cu_reg[0], cw_reg[2]);
                    2'd3: p_reg[3] <= smul32(cu_reg[0], cw_reg[1]);
                    default: p_reg[0] <= p_reg[0];
                endcase
            end
            B_CVOUT:
            begin
                // up axis cu x cw with cu_y zero
                cv_reg[0] <= 32'(rnd_half(-$signed(p_reg[0]), UNIT_FRAC));
                cv_reg[1] <= 32'(rnd_half($signed(p_reg[1]) - $signed(p_reg[2]), UNIT_FRAC));
                cv_reg[2] <= 32'(rnd_half($signed(p_reg[3]), UNIT_FRAC));
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

    assign basis = '{cu: cu_reg, cv: cv_reg, cw: cw_reg, degenerate: degen_reg};
    assign busy  = (state_reg != B_IDLE);

endmodule

@@ hdl/crd_ray_pipe.sv @@
// crd_ray_pipe: per-fragment pipeline, normalizes (fx, fy, focal) and maps it onto the basis
// depends on crd_pkg for the root and divide steps, rounding and payload types
module crd_ray_pipe
    import crd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  frag_t       frag,
    input  logic [15:0] focal,
    input  basis_t      basis,
    output logic        done,
    output ray_t        ray
);

    localparam int LAT = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1 + 4;
    localparam int MW  = 16 + FOCAL_SHIFT;

    typedef struct packed {
        sq_t              s;
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
    } sq_stage_t;

    typedef struct packed {
        logic [30:0]      n;
        logic [2:0][30:0] rem;
        logic [2:0][30:0] q;
        logic [2:0][30:0] dlo;
        logic [2:0]       neg;
        logic             zero;
    } dv_stage_t;

    logic [LAT-1:0] vld_reg;

    logic [2:0][MW-1:0] a_mag_reg;
    logic [MW-1:0]      a_max_reg;
    logic [2:0]         a_neg_reg;
    logic [2:0][29:0]   b_m_reg;
    logic [2:0]         b_neg_reg;
    logic               b_zero_reg;
    logic [2:0][59:0]   c_sq_reg;
    logic [2:0][29:0]   c_m_reg;
    logic [2:0]         c_neg_reg;
    logic               c_zero_reg;
    sq_stage_t          sq_reg [SQRT_STEPS+1];
    dv_stage_t          dv_reg [DIV_STEPS+1];
    logic [2:0][31:0]   f_r_reg;
    logic [2:0][2:0][63:0] g_p_reg;
    logic [2:0][63:0]   h_acc_reg;
    ray_t               ray_reg;

    logic [2:0][MW-1:0] mag_in;
    logic [MW-1:0]      max_in;
    logic [4:0]         msb;
    logic [30:0]        n_root;
    logic [2:0][60:0]   dividend;
    logic [2:0][15:0]   dir_val;

    function automatic logic [4:0] msb18(input logic [MW-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // magnitudes of the fragment vector
    always_comb
    begin
        mag_in[0] = MW'($unsigned(frag.frag_x[15] ? 16'(-frag.frag_x) : 16'(frag.frag_x)));
        mag_in[1] = MW'($unsigned(frag.frag_y[15] ? 16'(-frag.frag_y) : 16'(frag.frag_y)));
        mag_in[2] = MW'(focal) << FOCAL_SHIFT;
        max_in    = mag_in[0];
        for (int i = 1; i < 3; i++) begin
            if (mag_in[i] > max_in) begin
                max_in = mag_in[i];
            end
        end
        msb    = msb18(a_max_reg);
        n_root = sq_reg[SQRT_STEPS].s.r[30:0];
        for (int i = 0; i < 3; i++) begin
            dividend[i] = {1'b0, sq_reg[SQRT_STEPS].m[i], 30'b0} + 61'(n_root[30:1]);
        end
    end

    // output rounding and clamp
    always_comb
    begin
        logic signed [63:0] o;
        logic signed [63:0] lim;
        lim = 64'sd1 <<< DIR_FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            o = rnd_half($signed(h_acc_reg[i]), RND_SHIFT);
            if (o > lim) begin
                o = lim;
            end
            if (o < -lim) begin
                o = -lim;
            end
            dir_val[i] = basis.degenerate ? 16'd0 : o[15:0];
        end
    end

    // valid bits travel alongside the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        // stage a: magnitudes, signs and largest
        a_mag_reg <= mag_in;
        a_max_reg <= max_in;
        a_neg_reg <= {1'b0, frag.frag_y[15], frag.frag_x[15]};

        // stage b: shift largest to bit 29
        for (int i = 0; i < 3; i++) begin
            b_m_reg[i] <= 30'({12'b0, a_mag_reg[i]} << (5'd29 - msb));
        end
        b_neg_reg  <= a_neg_reg;
        b_zero_reg <= (a_max_reg == '0);

        // stage c: squares
        for (int i = 0; i < 3; i++) begin
            c_sq_reg[i] <= 60'(b_m_reg[i]) * 60'(b_m_reg[i]);
        end
        c_m_reg    <= b_m_reg;
        c_neg_reg  <= b_neg_reg;
        c_zero_reg <= b_zero_reg;

        // stage d: sum of squares enters the root pipe
        sq_reg[0].s.x  <= 62'(c_sq_reg[0]) + 62'(c_sq_reg[1]) + 62'(c_sq_reg[2]);
        sq_reg[0].s.r  <= '0;
        sq_reg[0].m    <= c_m_reg;
        sq_reg[0].neg  <= c_neg_reg;
        sq_reg[0].zero <= c_zero_reg;

        // root pipe, one result bit a stage
        for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_reg[k+1].s    <= sqrt_step(sq_reg[k].s, 5'(SQRT_STEPS - 1 - k));
            sq_reg[k+1].m    <= sq_reg[k].m;
            sq_reg[k+1].neg  <= sq_reg[k].neg;
            sq_reg[k+1].zero <= sq_reg[k].zero;
        end

        // dividend (m << 30) + n/2 for each lane
        dv_reg[0].n <= n_root;
        for (int i = 0; i < 3; i++) begin
            dv_reg[0].rem[i] <= {1'b0, dividend[i][60:31]};
            dv_reg[0].q[i]   <= '0;
            dv_reg[0].dlo[i] <= dividend[i][30:0];
        end
        dv_reg[0].neg  <= sq_reg[SQRT_STEPS].neg;
        dv_reg[0].zero <= sq_reg[SQRT_STEPS].zero;

        // three divide lanes, one quotient bit a stage
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int i = 0; i < 3; i++) begin
                {dv_reg[k+1].rem[i], dv_reg[k+1].q[i]} <=
                    div_step('{rem: dv_reg[k].rem[i], q: dv_reg[k].q[i]},
                             dv_reg[k].dlo[i][30], dv_reg[k].n);
                dv_reg[k+1].dlo[i] <= {dv_reg[k].dlo[i][29:0], 1'b0};
            end
            dv_reg[k+1].n    <= dv_reg[k].n;
            dv_reg[k+1].neg  <= dv_reg[k].neg;
            dv_reg[k+1].zero <= dv_reg[k].zero;
        end

        // stage f: signed unit fragment vector, zero vector looks straight ahead
        for (int i = 0; i < 3; i++) begin
            if (dv_reg[DIV_STEPS].zero) begin
                f_r_reg[i] <= (i == 2) ? (32'd1 << UNIT_FRAC) : 32'd0;
            end else if (dv_reg[DIV_STEPS].neg[i]) begin
                f_r_reg[i] <= -{1'b0, dv_reg[DIV_STEPS].q[i]};
            end else begin
                f_r_reg[i] <= {1'b0, dv_reg[DIV_STEPS].q[i]};
            end
        end

        // stage g: products with cu, cv, cw
        for (int i = 0; i < 3; i++) begin
            g_p_reg[i][0] <= smul32(f_r_reg[0], basis.cu[i]);
            g_p_reg[i][1] <= smul32(f_r_reg[1], basis.cv[i]);
            g_p_reg[i][2] <= smul32(f_r_reg[2], basis.cw[i]);
        end

        // stage h: accumulate
        for (int i = 0; i < 3; i++) begin
            h_acc_reg[i] <= g_p_reg[i][0] + g_p_reg[i][1] + g_p_reg[i][2];
        end

        // output register
        ray_reg.dir_x      <= dir_val[0];
        ray_reg.dir_y      <= dir_val[1];
        ray_reg.dir_z      <= dir_val[2];
        ray_reg.degenerate <= basis.degenerate;
    end

    assign done = vld_reg[LAT-1];
    assign ray  = ray_reg;

endmodule

@@ hdl/camera_ray_direction.sv @@
// camera_ray_direction: top level, configuration registers, basis builder and ray pipeline
// depends on crd_pkg, crd_basis and crd_ray_pipe
//
// Look-at camera ray generator. One fragment is taken per clock cycle whenever busy is
// low, and its unit direction (Q1.14) appears on ray with done high for one cycle;
// results come out in order and cannot be held off. The rate is set by the fully
// pipelined root and divide lanes that normalize the fragment vector. The camera basis
// is rebuilt by a sequential unit sharing one root step, one divide step, one squarer
// and one cross-product multiplier; after reset and after every configuration write busy
// stays high while this runs.
module camera_ray_direction
    import crd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  frag_t       frag,
    output logic        done,
    output ray_t        ray,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [2:0][31:0] eye_reg;
    logic [2:0][31:0] target_reg;
    logic [15:0]      focal_reg;
    logic             kick_reg;

    basis_t basis;
    logic   basis_busy;
    logic   accept;

    assign cfg_ready = 1'b1;
    assign busy      = kick_reg | basis_busy;
    assign accept    = start & ~busy;

    // configuration write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            eye_reg    <= {32'hFFFC_0000, 32'd0, 32'd0};
            target_reg <= '0;
            focal_reg  <= 16'd6144;
            kick_reg   <= 1'b1;
        end else begin
            kick_reg <= cfg_valid;
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_EYE_X:    eye_reg[0]    <= cfg_data;
                    REG_EYE_Y:    eye_reg[1]    <= cfg_data;
                    REG_EYE_Z:    eye_reg[2]    <= cfg_data;
                    REG_TARGET_X: target_reg[0] <= cfg_data;
                    REG_TARGET_Y: target_reg[1] <= cfg_data;
                    REG_TARGET_Z: target_reg[2] <= cfg_data;
                    REG_FOCAL:    focal_reg     <= cfg_data[15:0];
                    default:      focal_reg     <= focal_reg;
                endcase
            end
        end
    end

    crd_basis u_basis (
        .clk    (clk),
        .rst_n  (rst_n),
        .kick   (kick_reg),
        .eye    (eye_reg),
        .target (target_reg),
        .basis  (basis),
        .busy   (basis_busy)
    );

    crd_ray_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .frag     (frag),
        .focal    (focal_reg),
        .basis    (basis),
        .done     (done),
        .ray      (ray)
    );

endmodule
